>>> hw/rtl/respawn_round_robin_queues_macros.svh
// Assertion macros for the respawn round-robin queues.
// Used by the top level; expects clk and rst in scope.
`ifndef RESPAWN_ROUND_ROBIN_QUEUES_MACROS_SVH
`define RESPAWN_ROUND_ROBIN_QUEUES_MACROS_SVH

// Same-cycle implication.
`define RRQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/rrq_pkg.sv
// Package for the respawn round-robin queues: sizes, codes and types.
// No dependencies.
package rrq_pkg;

  localparam int TEAMS    = 4;
  localparam int SLOTS    = 16;
  localparam int FUNC_W   = 2;
  localparam int TEAM_W   = 2;
  localparam int ID_W     = 4;
  localparam int STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_ENQ = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEQ = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REM = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
  } slot_t;

  typedef slot_t [TEAMS-1:0] slot_vec_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_ENQ,
    OP_DEQ,
    OP_REM
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [TEAM_W-1:0] team;
    logic [ID_W-1:0]   id;
    logic [ID_W-1:0]   head;
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_REMOVE
  } state_t;

endpackage

>>> hw/rtl/rrq_in_if.sv
// Input channel of the respawn round-robin queues: valid/ready plus operation fields.
// Depends on rrq_pkg.
interface rrq_in_if;
  import rrq_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [TEAM_W-1:0] team_index;
  logic [ID_W-1:0]   player_id;

  modport source (output valid, func, team_index, player_id, input ready);
  modport sink (input valid, func, team_index, player_id, output ready);
endinterface

>>> hw/rtl/rrq_out_if.sv
// Output channel of the respawn round-robin queues: valid/ready plus result fields.
// Depends on rrq_pkg.
interface rrq_out_if;
  import rrq_pkg::*;

  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     out_player;
  logic [STATUS_W-1:0] status;

  modport source (output valid, out_player, status, input ready);
  modport sink (input valid, out_player, status, output ready);
endinterface

>>> hw/rtl/rrq_cell.sv
// One slot position of every team queue; takes its right neighbor on shifts.
// Depends on rrq_pkg.
module rrq_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  rrq_pkg::cell_cmd_t          cmd,
  input  rrq_pkg::slot_vec_t          right,
  input  logic [rrq_pkg::TEAMS-1:0]   left_valid,
  input  logic [rrq_pkg::TEAMS-1:0]   gap_in,
  output logic [rrq_pkg::TEAMS-1:0]   gap_out,
  output rrq_pkg::slot_vec_t          slots,
  output logic                        match
);
  import rrq_pkg::*;

  slot_vec_t        slots_next;
  logic [TEAMS-1:0] dead;
  logic [TEAMS-1:0] sel;

  always_comb begin
    slots_next = slots;
    for (int t = 0; t < TEAMS; t++) begin
      dead[t]    = slots[t].valid && (slots[t].id == cmd.id);
      gap_out[t] = gap_in[t] || dead[t];
      sel[t]     = (int'(cmd.team) == t);
      case (cmd.op)
        OP_ENQ: begin
          if (sel[t] && !slots[t].valid && left_valid[t]) begin
            slots_next[t] = '{valid: 1'b1, id: cmd.id};
          end
        end
        OP_DEQ: begin
          if (sel[t]) begin
            if (slots[t].valid && !right[t].valid) begin
              slots_next[t] = '{valid: 1'b1, id: cmd.head};
            end else begin
              slots_next[t] = right[t];
            end
          end
        end
        OP_REM: begin
          if (gap_out[t]) begin
            slots_next[t] = right[t];
          end
        end
        default: begin
        end
      endcase
    end
    match = |dead;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots <= '0;
    end else begin
      slots <= slots_next;
    end
  end

endmodule

>>> hw/rtl/respawn_round_robin_queues.sv
// Respawn round-robin queues: one packed queue per team, held in a chain of slot cells.
// Enqueue, dequeue and unused codes: result registered in the cycle after accept;
// one transaction per cycle while the output is taken. Remove: one occurrence per queue
// drops each cycle; result once no copy of the id is left; no input is taken meanwhile.
// Synchronous reset empties every slot and the output register.
// Depends on rrq_pkg, rrq_in_if, rrq_out_if, rrq_cell and the assertion macro header.
`include "respawn_round_robin_queues_macros.svh"

module respawn_round_robin_queues (
  input logic      clk,
  input logic      rst,
  rrq_in_if.sink   req,
  rrq_out_if.source rsp
);
  import rrq_pkg::*;

  slot_vec_t           cell_q     [SLOTS];
  slot_vec_t           cell_right [SLOTS];
  logic [TEAMS-1:0]    cell_left  [SLOTS];
  logic [TEAMS-1:0]    gap        [SLOTS+1];
  logic [SLOTS-1:0]    match_vec;
  logic                any_match;

  cell_cmd_t           cmd;
  state_t              state;
  state_t              state_next;
  logic [ID_W-1:0]     rem_id;
  logic [ID_W-1:0]     rem_id_next;
  logic                out_valid;
  logic [ID_W-1:0]     out_player;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     player_next;
  logic [STATUS_W-1:0] status_next;
  logic                load;
  logic                out_free;
  logic                in_fire;
  logic                team_ok;
  slot_t               head;
  logic                full;
  logic                pack_err;

  assign gap[0] = '0;

  for (genvar s = 0; s < SLOTS; s++) begin : g_cell
    if (s == SLOTS - 1) begin : g_last
      assign cell_right[s] = '0;
    end else begin : g_mid
      assign cell_right[s] = cell_q[s+1];
    end
    for (genvar t = 0; t < TEAMS; t++) begin : g_left
      if (s == 0) begin : g_first
        assign cell_left[s][t] = 1'b1;
      end else begin : g_rest
        assign cell_left[s][t] = cell_q[s-1][t].valid;
      end
    end
    rrq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .right     (cell_right[s]),
      .left_valid(cell_left[s]),
      .gap_in    (gap[s]),
      .gap_out   (gap[s+1]),
      .slots     (cell_q[s]),
      .match     (match_vec[s])
    );
  end

  assign any_match = |match_vec;
  assign team_ok   = (int'(req.team_index) < TEAMS);
  assign head      = cell_q[0][req.team_index];
  assign full      = cell_q[SLOTS-1][req.team_index].valid;
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign in_fire   = req.valid && req.ready;

  assign rsp.valid      = out_valid;
  assign rsp.out_player = out_player;
  assign rsp.status     = out_status;

  always_comb begin
    state_next  = state;
    rem_id_next = rem_id;
    load        = 1'b0;
    player_next = '0;
    status_next = STATUS_OK;
    cmd         = '{op: OP_HOLD, team: req.team_index, id: req.player_id, head: head.id};
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          load = 1'b1;
          case (req.func)
            FUNC_ENQ: begin
              if (team_ok && !full) begin
                cmd.op = OP_ENQ;
              end else begin
                status_next = STATUS_FULL;
              end
            end
            FUNC_DEQ: begin
              if (team_ok && head.valid) begin
                cmd.op      = OP_DEQ;
                player_next = head.id;
              end else begin
                status_next = STATUS_EMPTY;
              end
            end
            FUNC_REM: begin
              load        = 1'b0;
              cmd.op      = OP_REM;
              rem_id_next = req.player_id;
              state_next  = ST_REMOVE;
            end
            default: begin
            end
          endcase
        end
      end
      ST_REMOVE: begin
        cmd.op = OP_REM;
        cmd.id = rem_id;
        if (!any_match) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    rem_id <= rem_id_next;
    if (load) begin
      out_player <= player_next;
      out_status <= status_next;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    pack_err = 1'b0;
    for (int s = 0; s < SLOTS - 1; s++) begin
      for (int t = 0; t < TEAMS; t++) begin
        pack_err = pack_err || (cell_q[s+1][t].valid && !cell_q[s][t].valid);
      end
    end
  end

  `RRQ_ASSERT_IMPL(a_queues_packed, 1'b1, !pack_err, "queue slots not packed at the front")
  `RRQ_ASSERT_IMPL(a_remove_out_empty, state == ST_REMOVE, !out_valid, "output busy during remove")
  `RRQ_ASSERT_NEXT(a_remove_done, state == ST_REMOVE && !any_match, out_valid && out_status == STATUS_OK && out_player == '0, "remove result missing")

endmodule
